// File: src/sbfp_pkg.sv
`timescale 1ns / 1ps
// Package for the seven-bit field frame packer.
// Shared types and constants; used by sbfp_ctrl, sbfp_dpath and the top level.
package sbfp_pkg;

  localparam int unsigned ACC_W     = 39;  // six pending bits plus a 32-bit field, padded
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned WIDTH_W   = 6;
  localparam int unsigned ID_W      = 6;
  localparam int unsigned BYTE_BITS = 7;

  localparam logic [7:0]         HDR_MARK  = 8'h80;
  localparam logic [6:0]         COUNT_MAX = 7'd127;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH = 6'd32;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_HDR,
    ACT_DATA,
    ACT_PAD,
    ACT_TRL,
    ACT_DONE
  } act_e;

  typedef struct packed {
    act_e act;
    logic fin;   // emitted byte is the final one of the item
  } ctl_cmd_t;

  typedef struct packed {
    logic hdr_pend;
    logic t_ge7;
    logic t_ge14;
    logic t_nz;
    logic last;
    logic out_free;
  } ctl_sts_t;

endpackage

// File: src/sbfp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the frame packer: picks the datapath action each cycle.
// Depends on sbfp_pkg.
module sbfp_ctrl
  import sbfp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.act  = ACT_NONE;
    cmd_o.fin  = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.act = ACT_LOAD;
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.hdr_pend) begin
          if (sts_i.out_free) begin
            cmd_o.act = ACT_HDR;
            cmd_o.fin = !sts_i.last && !sts_i.t_ge7;
          end
        end else if (sts_i.t_ge7) begin
          if (sts_i.out_free) begin
            cmd_o.act = ACT_DATA;
            cmd_o.fin = !sts_i.last && !sts_i.t_ge14;
          end
        end else if (sts_i.last && sts_i.t_nz) begin
          if (sts_i.out_free) begin
            cmd_o.act = ACT_PAD;
          end
        end else if (sts_i.last) begin
          if (sts_i.out_free) begin
            cmd_o.act = ACT_TRL;
            cmd_o.fin = 1'b1;
            state_d   = ST_IDLE;
          end
        end else begin
          cmd_o.act = ACT_DONE;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/sbfp_dpath.sv
`timescale 1ns / 1ps
// Datapath of the frame packer: bit accumulator, frame state, output register.
// Depends on sbfp_pkg.
module sbfp_dpath
  import sbfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ID_W-1:0]    cfg_wdata_i,
  input  logic [FIELD_W-1:0] field_value_i,
  input  logic [WIDTH_W-1:0] field_width_i,
  input  logic               last_field_i,
  input  ctl_cmd_t           cmd_i,
  output ctl_sts_t           sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               frame_end_o,
  output logic               last_of_run_o
);

  logic [ID_W-1:0]    frame_id_q;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [5:0]         t_q, t_d;
  logic               last_q, last_d;
  logic               hdr_pend_q, hdr_pend_d;
  logic [6:0]         pend_bits_q, pend_bits_d;
  logic [2:0]         pend_cnt_q, pend_cnt_d;
  logic [6:0]         fcount_q, fcount_d;
  logic               in_frame_q, in_frame_d;
  logic               ovalid_q, ovalid_d;
  logic [7:0]         obyte_q, obyte_d;
  logic               oend_q, oend_d;
  logic               olast_q, olast_d;

  logic [WIDTH_W-1:0] width_sat;
  logic [FIELD_W-1:0] field_left;
  logic [6:0]         pend_left;
  logic [ACC_W-1:0]   acc_load;
  logic [6:0]         top7;
  logic [6:0]         fcount_inc;
  logic               emit;

  assign width_sat  = (field_width_i > MAX_WIDTH) ? MAX_WIDTH : field_width_i;
  assign field_left = field_value_i << (MAX_WIDTH - width_sat);
  assign pend_left  = pend_bits_q << (3'(BYTE_BITS) - pend_cnt_q);
  assign acc_load   = {pend_left, {FIELD_W{1'b0}}}
                    | ({field_left, 7'b0} >> pend_cnt_q);
  assign top7       = acc_q[ACC_W-1 -: 7];
  assign fcount_inc = (fcount_q == COUNT_MAX) ? COUNT_MAX : fcount_q + 7'd1;
  assign emit       = (cmd_i.act == ACT_HDR) || (cmd_i.act == ACT_DATA)
                   || (cmd_i.act == ACT_PAD) || (cmd_i.act == ACT_TRL);

  assign sts_o.hdr_pend = hdr_pend_q;
  assign sts_o.t_ge7    = (t_q >= 6'd7);
  assign sts_o.t_ge14   = (t_q >= 6'd14);
  assign sts_o.t_nz     = (t_q != 6'd0);
  assign sts_o.last     = last_q;
  assign sts_o.out_free = !ovalid_q || out_ready_i;

  always_comb begin
    acc_d       = acc_q;
    t_d         = t_q;
    last_d      = last_q;
    hdr_pend_d  = hdr_pend_q;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    fcount_d    = fcount_q;
    in_frame_d  = in_frame_q;
    ovalid_d    = ovalid_q && !out_ready_i;
    obyte_d     = obyte_q;
    oend_d      = oend_q;
    olast_d     = olast_q;
    if (emit) begin
      ovalid_d = 1'b1;
      olast_d  = cmd_i.fin;
      oend_d   = 1'b0;
      fcount_d = fcount_inc;
    end
    case (cmd_i.act)
      ACT_LOAD: begin
        acc_d      = acc_load;
        t_d        = {3'b0, pend_cnt_q} + width_sat;
        last_d     = last_field_i;
        hdr_pend_d = !in_frame_q;
      end
      ACT_HDR: begin
        obyte_d    = HDR_MARK | {2'b0, frame_id_q};
        hdr_pend_d = 1'b0;
        in_frame_d = 1'b1;
      end
      ACT_DATA: begin
        obyte_d = {1'b0, top7};
        acc_d   = acc_q << BYTE_BITS;
        t_d     = t_q - 6'd7;
      end
      ACT_PAD: begin
        obyte_d = {1'b0, top7};
        acc_d   = '0;
        t_d     = '0;
      end
      ACT_TRL: begin
        obyte_d     = HDR_MARK | {1'b0, fcount_inc};
        oend_d      = 1'b1;
        fcount_d    = '0;
        in_frame_d  = 1'b0;
        pend_bits_d = '0;
        pend_cnt_d  = '0;
        t_d         = '0;
      end
      ACT_DONE: begin
        pend_bits_d = top7 >> (3'(BYTE_BITS) - t_q[2:0]);
        pend_cnt_d  = t_q[2:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q  <= '0;
      t_q         <= '0;
      last_q      <= 1'b0;
      hdr_pend_q  <= 1'b0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      fcount_q    <= '0;
      in_frame_q  <= 1'b0;
      ovalid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_id_q <= cfg_wdata_i;
      end
      t_q         <= t_d;
      last_q      <= last_d;
      hdr_pend_q  <= hdr_pend_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      fcount_q    <= fcount_d;
      in_frame_q  <= in_frame_d;
      ovalid_q    <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    obyte_q <= obyte_d;
    oend_q  <= oend_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign out_byte_o    = obyte_q;
  assign frame_end_o   = oend_q;
  assign last_of_run_o = olast_q;

endmodule

// File: src/seven_bit_field_frame_packer.sv
`timescale 1ns / 1ps
// Top level of the seven-bit field frame packer.
// Instantiates sbfp_ctrl and sbfp_dpath; depends on sbfp_pkg.

// Each input item carries one field (value, width 0..32, last flag). The block
// takes one item at a time: the accept cycle loads the field behind the held
// pending bits, then one output byte per cycle, while the output is not
// stalled, leaves through the output register (header on the first field of a
// frame, 7-bit payload bytes MSB first, a zero-padded flush byte and the
// trailer on the last field). An item that ends without a trailer finishes
// with a step that keeps its leftover bits as the pending bits; the
// single-byte output register sets the pace. frame_id is sampled when the header byte is built.
module seven_bit_field_frame_packer
  import sbfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,     // frame_id
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // [31:0] field_value, [37:32] field_width, zero pad
  input  logic        s_axis_tlast,    // last_field
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
  output logic        m_axis_tuser,    // frame_end
  output logic        m_axis_tlast     // last_of_run
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  sbfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbfp_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .field_value_i (s_axis_tdata[31:0]),
    .field_width_i (s_axis_tdata[37:32]),
    .last_field_i  (s_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .frame_end_o   (m_axis_tuser),
    .last_of_run_o (m_axis_tlast)
  );

endmodule

// File: src/sbfp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the seven-bit field frame packer, bound to the top.
// Depends only on the top level's ports.
module sbfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // output held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous item still in work");

  // trailer ends the item's run and carries the marker bit
  a_trl_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7])
    else $error("trailer byte malformed");

  // input not ready while a stalled output byte is not the last of its item's run
  a_ready_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast && !m_axis_tready |-> !s_axis_tready)
    else $error("input ready in the middle of an item's run");

endmodule

bind seven_bit_field_frame_packer sbfp_checker u_sbfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
